// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/dht_pkg.sv -----
package dht_pkg;
  localparam int MAX_SLOTS_DEF = 64;
  localparam int SIZE_MIN = 5;
  localparam int STEP_OFFSET = 2;
  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int SIZE_W = 7;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_W = 7;
  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;
  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_INSERT = 1'b1;
endpackage

// ----- rtl/dht_req_if.sv -----
interface dht_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic [dht_pkg::KEY_W-1:0] key;
  logic [dht_pkg::PAY_W-1:0] payload;
  modport source (output valid, kind, key, payload, input ready);
  modport sink (input valid, kind, key, payload, output ready);
endinterface

// ----- rtl/dht_rsp_if.sv -----
interface dht_rsp_if;
  logic valid;
  logic ready;
  logic [dht_pkg::STATUS_W-1:0] status;
  logic [dht_pkg::PAY_W-1:0] payload_out;
  logic [dht_pkg::IDX_OUT_W-1:0] slot_index;
  logic [dht_pkg::CNT_W-1:0] entry_total;
  modport source (output valid, status, payload_out, slot_index, entry_total, input ready);
  modport sink (input valid, status, payload_out, slot_index, entry_total, output ready);
endinterface

// ----- rtl/double_hash_table_core.sv -----
// channel  | dir | contents
// req      | in  | kind, key, payload
// rsp      | out | status, payload_out, slot_index, entry_total
// cfg      | in  | cfg_we, cfg_data (table_size)
// per word: two key remainders on one shared 31-step divider,
// then one probe per slot memory read (S_READ then S_CHECK each, up to size probes)
// reset clears the valid bits and entry count at once, table_size goes to 7
// req stays low while a word is in work or its result waits on rsp
`include "assert_macros.svh"
module double_hash_table_core #(
  parameter int MAX_SLOTS = dht_pkg::MAX_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [dht_pkg::SIZE_W-1:0] cfg_data,
  dht_req_if.sink req,
  dht_rsp_if.source rsp
);
  localparam int AW = $clog2(MAX_SLOTS);
  localparam int VW = $clog2(MAX_SLOTS + 1);
  localparam int KW = dht_pkg::KEY_W;
  localparam int PW = dht_pkg::PAY_W;
  localparam int CW = dht_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD0, S_MOD1, S_READ, S_CHECK, S_DONE
  } state_t;
  state_t state;

  logic [dht_pkg::SIZE_W-1:0] table_size;
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [KW-1:0] slot_key [MAX_SLOTS];
  logic [PW-1:0] slot_payload [MAX_SLOTS];
  logic [KW-1:0] rd_key;
  logic [PW-1:0] rd_pay;
  logic [CW-1:0] entry_count;

  logic kind;
  logic [KW-1:0] key;
  logic [PW-1:0] pay;
  logic [VW-1:0] size;
  logic [AW-1:0] h0, h, step;
  logic [VW-1:0] probes;

  // effective size, saturated to the legal range
  logic [VW-1:0] size_sat;
  always_comb begin
    if (VW'(table_size) < VW'(dht_pkg::SIZE_MIN) && table_size < 7'(dht_pkg::SIZE_MIN))
      size_sat = VW'(dht_pkg::SIZE_MIN);
    else if ({{(VW+8){1'b0}}, table_size} > (VW+8+7)'(MAX_SLOTS))
      size_sat = VW'(MAX_SLOTS);
    else size_sat = VW'(table_size);
  end

  // shared divider, first remainder starts on the incoming key
  logic mstart, mdone;
  logic [VW-1:0] mdiv, mrem;
  logic [KW-1:0] mdividend;
  dht_mod_unit #(.DW(KW), .VW(VW)) u_mod (
    .clk(clk), .rst(rst), .start(mstart), .dividend(mdividend),
    .divisor(mdiv), .done(mdone), .remainder(mrem)
  );
  assign mstart = (state == S_IDLE && req.valid) ||
                  (state == S_MOD0 && mdone);
  assign mdiv = (state == S_IDLE) ? size_sat : size - VW'(dht_pkg::STEP_OFFSET);
  assign mdividend = (state == S_IDLE) ? req.key : key;

  // next slot: h + step, wrapped once
  logic [VW:0] hsum;
  logic [AW-1:0] hnext;
  always_comb begin
    hsum = {1'b0, VW'(h)} + {1'b0, VW'(step)};
    hnext = (hsum >= {1'b0, size}) ? AW'(hsum - {1'b0, size}) : AW'(hsum);
  end

  logic sv;
  logic hit;
  assign sv = slot_valid[h];
  assign hit = !sv || (rd_key == key);

  // slot key and payload memories, registered read
  always_ff @(posedge clk) begin
    rd_key <= slot_key[h];
    rd_pay <= slot_payload[h];
    if (state == S_CHECK && hit && kind == dht_pkg::KIND_INSERT) begin
      slot_payload[h] <= pay;
      if (!sv) slot_key[h] <= key;
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      table_size <= 7'd7;
      slot_valid <= '0;
      entry_count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) table_size <= cfg_data;
      case (state)
        S_IDLE: if (req.valid) begin
          kind <= req.kind;
          key <= req.key;
          pay <= req.payload;
          size <= size_sat;
          state <= S_MOD0;
        end
        S_MOD0: if (mdone) begin
          h0 <= AW'(mrem);
          h <= AW'(mrem);
          state <= S_MOD1;
        end
        S_MOD1: if (mdone) begin
          step <= AW'(size - VW'(dht_pkg::STEP_OFFSET) - mrem);
          probes <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (hit || hnext == h0) begin
            state <= S_DONE;
            rsp.valid <= 1'b1;
            rsp.payload_out <= '0;
            rsp.slot_index <= '0;
            rsp.entry_total <= entry_count;
            if (kind == dht_pkg::KIND_SEARCH) begin
              if (hit && sv) begin
                rsp.status <= dht_pkg::ST_FOUND;
                rsp.payload_out <= rd_pay;
                rsp.slot_index <= dht_pkg::IDX_OUT_W'(h);
              end else rsp.status <= dht_pkg::ST_NOT_FOUND;
            end else if (!hit) begin
              rsp.status <= dht_pkg::ST_FULL;
            end else begin
              rsp.payload_out <= pay;
              rsp.slot_index <= dht_pkg::IDX_OUT_W'(h);
              if (sv) rsp.status <= dht_pkg::ST_REPLACED;
              else begin
                rsp.status <= dht_pkg::ST_INSERTED;
                slot_valid[h] <= 1'b1;
                if (entry_count != {CW{1'b1}}) begin
                  entry_count <= entry_count + 1'b1;
                  rsp.entry_total <= entry_count + 1'b1;
                end
              end
            end
          end else begin
            h <= hnext;
            probes <= probes + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: if (rsp.ready) begin
          rsp.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_IMPLIES(a_busy_ready, clk, rst, state != S_IDLE, !req.ready)
  `ASSERT_IMPLIES(a_probe_bound, clk, rst, state == S_CHECK, probes < size)
  `ASSERT_NEXT(a_count_step, clk, rst, rsp.valid && rsp.ready, !rsp.valid)
endmodule

// ----- rtl/dht_mod_unit.sv -----
// restoring remainder, one quotient bit per cycle
module dht_mod_unit #(
  parameter int DW = dht_pkg::KEY_W,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] remainder
);
  localparam int CW = $clog2(DW + 1);
  logic [VW:0]   rem;
  logic [DW-1:0] sh;
  logic [VW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic [VW+1:0] diff;

  always_comb begin
    trial = {rem[VW-1:0], sh[DW-1]};
    diff = {1'b0, trial} - {2'b0, dv};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem <= '0;
      sh <= dividend;
      dv <= divisor;
      cnt <= CW'(DW);
    end else if (busy) begin
      sh <= {sh[DW-2:0], 1'b0};
      rem <= diff[VW+1] ? trial : diff[VW:0];
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign remainder = rem[VW-1:0];
endmodule

// ----- tb/tb_double_hash_table_core.sv -----
module tb_double_hash_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dht_pkg::*;

  localparam int SLOTS = MAX_SLOTS_DEF;

  // one expected response word
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PAY_W-1:0]     payload_out;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [CNT_W-1:0]     entry_total;
  } lookup_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_data;

  dht_req_if req ();
  dht_rsp_if rsp ();

  double_hash_table_core #(.MAX_SLOTS(SLOTS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  // shadow copy of the table contents and the size register
  logic [SIZE_W-1:0] shadow_size;
  logic              shadow_valid [SLOTS];
  logic [KEY_W-1:0]  shadow_key [SLOTS];
  logic [PAY_W-1:0]  shadow_pay [SLOTS];
  logic [CNT_W-1:0]  shadow_count;

  lookup_result_t pending_results[$];
  int mismatch_count;
  int words_sent;

  // keys reused within a phase so that hits, replaces and full tables show up
  logic [KEY_W-1:0] key_pool[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous limit: ~2000 words, with stalls
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  // walk the probe sequence the way the table does and update the shadow
  function automatic lookup_result_t predict_lookup(logic kind, logic [KEY_W-1:0] key,
                                                    logic [PAY_W-1:0] pay);
    lookup_result_t r;
    int s;
    int h0;
    int stride;
    int h;
    bit hit;
    s = int'(shadow_size);
    if (s < SIZE_MIN) s = SIZE_MIN;
    if (s > SLOTS) s = SLOTS;
    h0 = int'(key % s);
    stride = (s - STEP_OFFSET) - int'(key % (s - STEP_OFFSET));
    h = h0;
    hit = 1'b0;
    r = '0;
    do begin
      if (!shadow_valid[h] || shadow_key[h] == key) begin
        hit = 1'b1;
        break;
      end
      h = (h + stride) % s;
    end while (h != h0);
    if (kind == KIND_SEARCH) begin
      if (hit && shadow_valid[h]) begin
        r.status = ST_FOUND;
        r.payload_out = shadow_pay[h];
        r.slot_index = h[IDX_OUT_W-1:0];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (!hit) begin
      r.status = ST_FULL;
    end else begin
      if (shadow_valid[h]) begin
        r.status = ST_REPLACED;
      end else begin
        r.status = ST_INSERTED;
        shadow_valid[h] = 1'b1;
        shadow_key[h] = key;
        if (shadow_count != 7'd127) shadow_count = shadow_count + 1'b1;
      end
      shadow_pay[h] = pay;
      r.payload_out = pay;
      r.slot_index = h[IDX_OUT_W-1:0];
    end
    r.entry_total = shadow_count;
    return r;
  endfunction

  // mostly short gaps, a few long ones, runs of none
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one request word and record its expected response on acceptance
  task automatic send_word(logic kind, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    req.kind = kind;
    req.key = key;
    req.payload = pay;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_lookup(kind, key, pay));
    words_sent++;
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  // wait for the table to drain, then write the size register
  task automatic write_size(logic [SIZE_W-1:0] value);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_size = value;
  endtask

  // response side stall pattern: stretches with no stall, others with random stalls
  initial begin
    int stretch;
    bit stalling;
    rsp.ready = 1'b0;
    forever begin
      stretch = $urandom_range(20, 400);
      stalling = $urandom_range(0, 2) != 0;
      repeat (stretch) begin
        @(negedge clk);
        if (!stalling) rsp.ready = 1'b1;
        else if ($urandom_range(0, 19) == 0) rsp.ready = 1'b0;
        else if ($urandom_range(0, 9) < 6) rsp.ready = 1'b1;
        else rsp.ready = 1'b0;
      end
    end
  end

  // compare each response word against the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response word: status %0d", rsp.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status || rsp.payload_out !== want.payload_out ||
            rsp.slot_index !== want.slot_index || rsp.entry_total !== want.entry_total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: want st %0d pay %h idx %0d cnt %0d, got st %0d pay %h idx %0d cnt %0d",
                     want.status, want.payload_out, want.slot_index, want.entry_total,
                     rsp.status, rsp.payload_out, rsp.slot_index, rsp.entry_total);
        end
      end
    end
  end

  // edge keys, replace, collisions until full, search on a full table
  task automatic test_directed();
    int i;
    send_word(KIND_SEARCH, '0, '1);
    send_word(KIND_INSERT, '0, '0);
    send_word(KIND_INSERT, '1, '1);
    send_word(KIND_SEARCH, '0, '0);
    send_word(KIND_SEARCH, '1, '0);
    send_word(KIND_INSERT, '0, 32'hA5A5_5A5A);
    send_word(KIND_SEARCH, '0, '0);
    // keys that all hash to slot 0 at size 7
    for (i = 1; i <= 7; i++) send_word(KIND_INSERT, KEY_W'(7 * i), $urandom());
    send_word(KIND_SEARCH, KEY_W'(7 * 50), '0);
    send_word(KIND_SEARCH, KEY_W'(7 * 3), '0);
    send_word(KIND_INSERT, KEY_W'(12345), $urandom());
  endtask

  // random phase at one size: mostly pool keys, some fresh full-width keys
  task automatic test_size_phase(logic [SIZE_W-1:0] size_value, int words);
    int i;
    int pool_len;
    logic [KEY_W-1:0] k;
    write_size(size_value);
    key_pool.delete();
    pool_len = (size_value < SIZE_MIN ? SIZE_MIN : (size_value > SLOTS ? SLOTS : size_value));
    pool_len = pool_len + pool_len / 3 + 2;
    for (i = 0; i < pool_len; i++) key_pool.push_back(KEY_W'($urandom()));
    for (i = 0; i < words; i++) begin
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, pool_len - 1)];
      else k = KEY_W'($urandom());
      send_word($urandom_range(0, 1) ? KIND_INSERT : KIND_SEARCH, k, $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.kind = KIND_SEARCH;
    req.key = '0;
    req.payload = '0;
    mismatch_count = 0;
    words_sent = 0;
    shadow_size = SIZE_W'(7);
    shadow_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_pay[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_size_phase(SIZE_W'(5), 120);
    test_size_phase(SIZE_W'(0), 60);     // saturates to the minimum size
    test_size_phase(SIZE_W'(13), 200);
    test_size_phase(SIZE_W'(9), 150);    // not prime, short probe cycles
    test_size_phase(SIZE_W'(31), 300);
    test_size_phase(SIZE_W'(61), 400);
    test_size_phase(SIZE_W'(64), 300);   // largest, not prime
    test_size_phase(SIZE_W'(127), 200);  // saturates to the maximum size
    test_size_phase(SIZE_W'(7), 200);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
